// File: rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared constants, register indexes and command types of the tilt PID block.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int DivSteps = 13;

   localparam logic [2:0] CSR_SETPOINT    = 3'd0;
   localparam logic [2:0] CSR_GAIN_P      = 3'd1;
   localparam logic [2:0] CSR_GAIN_I      = 3'd2;
   localparam logic [2:0] CSR_GAIN_D      = 3'd3;
   localparam logic [2:0] CSR_DEAD_BAND   = 3'd4;
   localparam logic [2:0] CSR_INTEG_UPPER = 3'd5;
   localparam logic [2:0] CSR_INTEG_LOWER = 3'd6;
   localparam logic [2:0] CSR_DUTY_NEUTRAL = 3'd7;

   localparam logic signed [16:0] RST_SETPOINT     = 17'sd0;
   localparam logic [31:0]        RST_GAIN_P       = 32'd42598;
   localparam logic [31:0]        RST_GAIN_I       = 32'd393;
   localparam logic [31:0]        RST_GAIN_D       = 32'd10485760;
   localparam logic [15:0]        RST_DEAD_BAND    = 16'd205;
   localparam logic signed [15:0] RST_INTEG_UPPER  = 16'sd4352;
   localparam logic signed [15:0] RST_INTEG_LOWER  = -16'sd3840;
   localparam logic [6:0]         RST_DUTY_NEUTRAL = 7'd39;

   localparam logic [6:0]         DUTY_RIGHT = 7'd44;
   localparam logic signed [8:0]  DUTY_MAX   = 9'sd100;
   localparam logic signed [14:0] D_MAX      = 15'sd5120;
   localparam logic signed [14:0] D_MIN      = -15'sd3328;
   localparam logic signed [34:0] SUM_MAX    = 35'sd6400;
   localparam logic signed [34:0] SUM_MIN    = -35'sd5120;
   localparam logic signed [17:0] ERR_MAX    = 18'sd65535;
   localparam logic signed [17:0] ERR_MIN    = -18'sd65536;
   localparam logic [18:0]        STEP_SAT   = 19'd262144;

   typedef enum logic [2:0] {
      MUL_P,
      MUL_I,
      MUL_LO,
      MUL_HI,
      MUL_D
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       calc_err;
      logic       mul_en;
      mul_op_type mul_op;
      logic       combine;
      logic       div_step;
      logic       finish;
   } pdc_cmd_type;

endpackage

// File: rtl/pdc_req_if.sv
// ----------------------------------------------------------------------------
// pdc_req_if
// Sample channel: tilt angle and tick stamp with valid/ready.
// ----------------------------------------------------------------------------
interface pdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] angle_sample;
   logic [31:0]        time_stamp;

   modport source (output valid, angle_sample, time_stamp, input ready);
   modport sink   (input valid, angle_sample, time_stamp, output ready);
endinterface

// File: rtl/pdc_rsp_if.sv
// ----------------------------------------------------------------------------
// pdc_rsp_if
// Result channel: motor duties and clamped control sum with valid/ready.
// ----------------------------------------------------------------------------
interface pdc_rsp_if;
   logic               valid;
   logic               ready;
   logic [6:0]         duty_left;
   logic [6:0]         duty_right;
   logic signed [13:0] control_sum;

   modport source (output valid, duty_left, duty_right, control_sum, input ready);
   modport sink   (input valid, duty_left, duty_right, control_sum, output ready);
endinterface

// File: rtl/pdc_ctrl.sv
// ----------------------------------------------------------------------------
// pdc_ctrl
// Sequencer: walks one sample through error, multiplies, divide and output.
// ----------------------------------------------------------------------------
module pdc_ctrl
   import pdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pdc_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_ERR, S_MP, S_MI, S_ML, S_MH, S_MD, S_COMB, S_DIV, S_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      cmd.mul_op = MUL_P;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_ERR;
         end
         S_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = S_MP;
         end
         S_MP: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_P;
            state_in   = S_MI;
         end
         S_MI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_I;
            state_in   = S_ML;
         end
         S_ML: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_LO;
            state_in   = S_MH;
         end
         S_MH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_HI;
            state_in   = S_MD;
         end
         S_MD: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_D;
            state_in   = S_COMB;
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            count_in    = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 4'd1;
            if (count_ff == 4'(DivSteps - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output slot frees up
            if (slot_free) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/pdc_datapath.sv
// ----------------------------------------------------------------------------
// pdc_datapath
// Control registers, loop state, shared multiplier, divider and output terms.
// ----------------------------------------------------------------------------
module pdc_datapath
   import pdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pdc_cmd_type        cmd,
   input  logic signed [16:0] in_angle,
   input  logic [31:0]        in_stamp,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output logic [6:0]         out_duty_left,
   output logic signed [13:0] out_control_sum
);

   // control registers
   logic signed [16:0] setpoint_ff;
   logic [31:0]        gain_p_ff, gain_i_ff, gain_d_ff;
   logic [15:0]        dead_band_ff;
   logic signed [15:0] integ_upper_ff, integ_lower_ff;
   logic [6:0]         duty_neutral_ff;

   // loop state
   logic signed [15:0] integ_acc_ff;
   logic signed [16:0] last_error_ff;
   logic [31:0]        last_stamp_ff;

   // per-sample working registers
   logic signed [16:0] angle_ff, err_ff;
   logic [31:0]        stamp_ff, elapsed_ff;
   logic signed [32:0] p_ff;
   logic [48:0]        mag_ff;
   logic [55:0]        pl_ff;
   logic [56:0]        ph_ff;
   logic signed [50:0] dprod_ff;
   logic signed [15:0] int_ff;
   logic [49:0]        rem_ff;
   logic [59:0]        dv_ff;
   logic [12:0]        q_ff;
   logic               dsat_ff;
   logic [6:0]         duty_ff;
   logic signed [13:0] sum_ff;

   // error
   logic signed [17:0] raw_err;
   logic signed [16:0] sat_err, err_in;
   logic [17:0]        sat_mag, err_mag;
   logic signed [17:0] diff;

   always_comb begin
      raw_err = 18'(setpoint_ff) - 18'(angle_ff);
      if (raw_err > ERR_MAX)      sat_err = 17'(ERR_MAX);
      else if (raw_err < ERR_MIN) sat_err = 17'(ERR_MIN);
      else                        sat_err = raw_err[16:0];
      // negate in 18 bits: the most negative error is -65536
      sat_mag = sat_err[16] ? 18'(-18'(sat_err)) : 18'(sat_err);
      err_in  = (sat_mag <= {2'b0, dead_band_ff}) ? 17'sd0 : sat_err;
      err_mag = err_ff[16] ? 18'(-18'(err_ff)) : 18'(err_ff);
      diff    = 18'(err_ff) - 18'(last_error_ff);
   end

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_res;
   logic signed [48:0] p_prod, p_adj;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_P: begin
            mul_a = $signed({1'b0, gain_p_ff});
            mul_b = 33'(err_ff);
         end
         MUL_I: begin
            mul_a = $signed({1'b0, gain_i_ff});
            mul_b = $signed({15'b0, err_mag});
         end
         MUL_LO: begin
            mul_a = $signed({9'b0, mag_ff[23:0]});
            mul_b = $signed({1'b0, elapsed_ff});
         end
         MUL_HI: begin
            mul_a = $signed({8'b0, mag_ff[48:24]});
            mul_b = $signed({1'b0, elapsed_ff});
         end
         MUL_D: begin
            mul_a = $signed({1'b0, gain_d_ff});
            mul_b = 33'(diff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_res = 66'(mul_a) * 66'(mul_b);
      p_prod  = mul_res[48:0];
      p_adj   = p_prod + (p_prod[48] ? 49'sd65535 : 49'sd0);
   end

   // integral step and divider setup
   logic [81:0]        step_prod;
   logic [65:0]        step_q;
   logic [18:0]        step_mag;
   logic signed [19:0] step_s, int_sum, int_pick;
   logic signed [15:0] int_in;
   logic [49:0]        dx;

   always_comb begin
      step_prod = {1'b0, ph_ff, 24'b0} + {26'b0, pl_ff};
      step_q    = step_prod[81:16];
      step_mag  = (step_q > 66'(STEP_SAT)) ? STEP_SAT : step_q[18:0];
      step_s    = err_ff[16] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      int_sum   = 20'(integ_acc_ff) + step_s;
      int_pick  = (err_ff == 17'sd0) ? 20'sd0 : int_sum;
      if (int_pick > 20'(integ_upper_ff)) int_pick = 20'(integ_upper_ff);
      if (int_pick < 20'(integ_lower_ff)) int_pick = 20'(integ_lower_ff);
      int_in    = int_pick[15:0];
      dx        = dprod_ff[50] ? 50'(-dprod_ff) : 50'(dprod_ff);
   end

   // output terms
   logic [12:0]        d_mag;
   logic signed [14:0] d_sgn, d_val;
   logic signed [34:0] sum_raw, sum_cl;
   logic signed [13:0] sum_in, sum_adj;
   logic signed [5:0]  whole;
   logic signed [8:0]  duty_raw;
   logic [6:0]         duty_in;

   always_comb begin
      d_mag = dsat_ff ? 13'h1FFF : q_ff;
      d_sgn = diff[17] ? -$signed({2'b0, d_mag}) : $signed({2'b0, d_mag});
      if (elapsed_ff == 32'd0) begin
         if (diff > 18'sd0)      d_val = D_MAX;
         else if (diff < 18'sd0) d_val = D_MIN;
         else                    d_val = 15'sd0;
      end else if (d_sgn > D_MAX) begin
         d_val = D_MAX;
      end else if (d_sgn < D_MIN) begin
         d_val = D_MIN;
      end else begin
         d_val = d_sgn;
      end
      sum_raw = 35'(p_ff) + 35'(int_ff) + 35'(d_val);
      if (sum_raw > SUM_MAX)      sum_cl = SUM_MAX;
      else if (sum_raw < SUM_MIN) sum_cl = SUM_MIN;
      else                        sum_cl = sum_raw;
      sum_in   = sum_cl[13:0];
      // truncate toward zero on the way to whole percent
      sum_adj  = sum_in + (sum_in[13] ? 14'sd255 : 14'sd0);
      whole    = sum_adj[13:8];
      duty_raw = $signed({2'b0, duty_neutral_ff}) + 9'(whole);
      if (duty_raw > DUTY_MAX)     duty_in = 7'(DUTY_MAX);
      else if (duty_raw < 9'sd0)   duty_in = 7'd0;
      else                         duty_in = duty_raw[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= RST_SETPOINT;
         gain_p_ff       <= RST_GAIN_P;
         gain_i_ff       <= RST_GAIN_I;
         gain_d_ff       <= RST_GAIN_D;
         dead_band_ff    <= RST_DEAD_BAND;
         integ_upper_ff  <= RST_INTEG_UPPER;
         integ_lower_ff  <= RST_INTEG_LOWER;
         duty_neutral_ff <= RST_DUTY_NEUTRAL;
         integ_acc_ff    <= '0;
         last_error_ff   <= '0;
         last_stamp_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SETPOINT:     setpoint_ff     <= csr_write_data[16:0];
               CSR_GAIN_P:       gain_p_ff       <= csr_write_data;
               CSR_GAIN_I:       gain_i_ff       <= csr_write_data;
               CSR_GAIN_D:       gain_d_ff       <= csr_write_data;
               CSR_DEAD_BAND:    dead_band_ff    <= csr_write_data[15:0];
               CSR_INTEG_UPPER:  integ_upper_ff  <= csr_write_data[15:0];
               CSR_INTEG_LOWER:  integ_lower_ff  <= csr_write_data[15:0];
               CSR_DUTY_NEUTRAL: duty_neutral_ff <= csr_write_data[6:0];
               default: ;
            endcase
         end
         if (cmd.finish) begin
            integ_acc_ff  <= int_ff;
            last_error_ff <= err_ff;
            last_stamp_ff <= stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         angle_ff <= in_angle;
         stamp_ff <= in_stamp;
      end
      if (cmd.calc_err) begin
         err_ff     <= err_in;
         elapsed_ff <= stamp_ff - last_stamp_ff;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_op)
            MUL_P:   p_ff     <= p_adj[48:16];
            MUL_I:   mag_ff   <= mul_res[48:0];
            MUL_LO:  pl_ff    <= mul_res[55:0];
            MUL_HI:  ph_ff    <= mul_res[56:0];
            MUL_D:   dprod_ff <= mul_res[50:0];
            default: ;
         endcase
      end
      if (cmd.combine) begin
         int_ff  <= int_in;
         rem_ff  <= dx;
         dv_ff   <= {elapsed_ff, 28'b0};
         dsat_ff <= {11'b0, dx} >= {elapsed_ff, 29'b0};
         q_ff    <= '0;
      end
      if (cmd.div_step) begin
         if ({10'b0, rem_ff} >= dv_ff) begin
            rem_ff <= rem_ff - dv_ff[49:0];
            q_ff   <= {q_ff[11:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[11:0], 1'b0};
         end
         dv_ff <= dv_ff >> 1;
      end
      if (cmd.finish) begin
         duty_ff <= duty_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_duty_left   = duty_ff;
   assign out_control_sum = sum_ff;

endmodule

// File: rtl/pid_deadband_duty_controller_top.sv
// ----------------------------------------------------------------------------
// pid_deadband_duty_controller_top
// Tilt PID controller with deadband, integral clamp and duty output.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one beat per sample: Q8.8 angle and tick stamp.
//   rsp_chan returns one beat per sample: left duty, right duty (always 44)
//   and the clamped Q5.8 control sum.
//   csr_* writes one control register per cycle; write only while idle.
// Timing:
//   From accept to a valid result a sample passes through an error step,
//   five passes through the shared 33x33 multiplier, a combine step,
//   13 steps of the restoring divider for the derivative term and a final
//   output step that waits while the output slot is full. A new sample can
//   be taken in the cycle after the result is loaded, not before.
// Reset:
//   Synchronous reset restores register defaults, clears the integral,
//   previous error and previous stamp, and empties the output slot.
// Backpressure:
//   The result waits in its output register; a new sample is still taken and
//   computed, and its result holds in the last step until the slot frees.
// ----------------------------------------------------------------------------
module pid_deadband_duty_controller_top
   import pdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pdc_req_if.sink      req_chan,
   pdc_rsp_if.source    rsp_chan,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_write_data
);

   pdc_cmd_type cmd;

   pdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   pdc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_angle        (req_chan.angle_sample),
      .in_stamp        (req_chan.time_stamp),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .out_duty_left   (rsp_chan.duty_left),
      .out_control_sum (rsp_chan.control_sum)
   );

   assign rsp_chan.duty_right = DUTY_RIGHT;

endmodule

// File: rtl/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the tilt PID block, bound to the top level.
// ----------------------------------------------------------------------------
module pdc_checker
   import pdc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [6:0]         duty_left,
   input logic [6:0]         duty_right,
   input logic signed [13:0] control_sum
);

   // a pending result beat stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // one sample in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while another is in flight");

   a_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> duty_right == DUTY_RIGHT)
      else $error("right duty is not the fixed value");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> duty_left <= 7'd100 && control_sum >= -14'sd5120
                    && control_sum <= 14'sd6400)
      else $error("result out of range");

endmodule

bind pid_deadband_duty_controller_top pdc_checker u_pdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .duty_left   (rsp_chan.duty_left),
   .duty_right  (rsp_chan.duty_right),
   .control_sum (rsp_chan.control_sum)
);

// File: verif/tb_pid_deadband_duty_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_deadband_duty_controller_top
// Drives tilt samples through the PID block under random bursts and result
// stalls and checks each result beat against a cycle-free duty predictor,
// across several register settings that include the extremes.
// ----------------------------------------------------------------------------
module tb_pid_deadband_duty_controller_top;
   import pdc_pkg::*;

   localparam int IdleLimit = 4000;
   localparam int SettleCycles = 40;

   typedef struct {
      logic [6:0]         duty_left;
      logic [6:0]         duty_right;
      logic signed [13:0] control_sum;
   } duty_beat_t;

   class duty_scoreboard;
      logic signed [16:0] setpoint;
      logic [31:0]        gain_p, gain_i, gain_d;
      logic [15:0]        dead_band;
      logic signed [15:0] integ_upper, integ_lower;
      logic [6:0]         duty_neutral;
      longint             integ_acc, last_err;
      logic [31:0]        last_stamp;
      duty_beat_t         expected_duty_q[$];
      int                 fails;

      function new();
         setpoint = RST_SETPOINT;
         gain_p = RST_GAIN_P;
         gain_i = RST_GAIN_I;
         gain_d = RST_GAIN_D;
         dead_band = RST_DEAD_BAND;
         integ_upper = RST_INTEG_UPPER;
         integ_lower = RST_INTEG_LOWER;
         duty_neutral = RST_DUTY_NEUTRAL;
         integ_acc = 0;
         last_err = 0;
         last_stamp = '0;
         fails = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_SETPOINT:     setpoint = data[16:0];
            CSR_GAIN_P:       gain_p = data;
            CSR_GAIN_I:       gain_i = data;
            CSR_GAIN_D:       gain_d = data;
            CSR_DEAD_BAND:    dead_band = data[15:0];
            CSR_INTEG_UPPER:  integ_upper = data[15:0];
            CSR_INTEG_LOWER:  integ_lower = data[15:0];
            CSR_DUTY_NEUTRAL: duty_neutral = data[6:0];
            default: ;
         endcase
      endfunction

      // Predict the result of one accepted sample and advance the PID state.
      function void note_sample(logic signed [16:0] ang, logic [31:0] stamp);
         longint err, p, ii, d, sum, diff, ge, duty, el_s;
         longint unsigned mag, el_u, lim;
         duty_beat_t b;
         el_u = {32'b0, stamp - last_stamp};
         el_s = longint'(el_u);
         err = longint'(setpoint) - longint'(ang);
         if (err > 65535) err = 65535;
         if (err < -65536) err = -65536;
         if ((err < 0 ? -err : err) <= longint'({48'b0, dead_band})) err = 0;

         p = (longint'({32'b0, gain_p}) * err) / 64'sd65536;

         ge = longint'({32'b0, gain_i}) * err;
         mag = longint'(ge < 0 ? -ge : ge);
         if (el_u != 0) lim = (64'd1 << 62) / el_u;
         else lim = '1;
         if (el_u != 0 && mag > lim) ii = 64'sd1 <<< 46;
         else ii = longint'((mag * el_u) >> 16);
         if (ge < 0) ii = -ii;
         ii = integ_acc + ii;
         if (err == 0) ii = 0;
         if (ii > longint'(integ_upper)) ii = longint'(integ_upper);
         if (ii < longint'(integ_lower)) ii = longint'(integ_lower);
         integ_acc = ii;

         diff = err - last_err;
         if (el_u == 0) begin
            d = diff > 0 ? 5120 : (diff < 0 ? -3328 : 0);
         end else begin
            d = (longint'({32'b0, gain_d}) * diff) / el_s / 64'sd65536;
            if (d > 5120) d = 5120;
            if (d < -3328) d = -3328;
         end

         sum = p + ii + d;
         if (sum > 6400) sum = 6400;
         if (sum < -5120) sum = -5120;
         duty = longint'({57'b0, duty_neutral}) + sum / 64'sd256;
         if (duty > 100) duty = 100;
         if (duty < 0) duty = 0;

         last_err = err;
         last_stamp = stamp;
         b.duty_left = duty[6:0];
         b.duty_right = 7'd44;
         b.control_sum = sum[13:0];
         expected_duty_q.push_back(b);
      endfunction

      function void check_beat(logic [6:0] dl, logic [6:0] dr, logic signed [13:0] cs);
         duty_beat_t b;
         if (expected_duty_q.size() == 0) begin
            $display("%0t: unexpected result beat dl=%0d dr=%0d sum=%0d",
                     $time, dl, dr, cs);
            fails++;
            return;
         end
         b = expected_duty_q.pop_front();
         if (dl !== b.duty_left) begin
            $display("%0t: duty_left expected %0d actual %0d", $time, b.duty_left, dl);
            fails++;
         end
         if (dr !== b.duty_right) begin
            $display("%0t: duty_right expected %0d actual %0d", $time, b.duty_right, dr);
            fails++;
         end
         if (cs !== b.control_sum) begin
            $display("%0t: control_sum expected %0d actual %0d", $time, b.control_sum, cs);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   pdc_req_if req_chan ();
   pdc_rsp_if rsp_chan ();

   pid_deadband_duty_controller_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan.sink),
      .rsp_chan       (rsp_chan.source),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   duty_scoreboard sb = new();
   logic [31:0]    cur_stamp;
   int             burst_left;
   int             idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_sample(req_chan.angle_sample, req_chan.time_stamp);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_beat(rsp_chan.duty_left, rsp_chan.duty_right, rsp_chan.control_sum);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("** pid_deadband_duty_controller_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: the stall pattern switches between four random modes.
   int rx_mode, rx_stall, rx_cnt;
   initial begin
      rsp_chan.ready = 1'b0;
      rx_mode = 0;
      rx_stall = 0;
      rx_cnt = 0;
      forever begin
         @(negedge clock);
         rx_cnt++;
         if (rx_cnt % 300 == 0) rx_mode = $urandom_range(0, 3);
         if (rx_stall > 0) begin
            rsp_chan.ready = 1'b0;
            rx_stall--;
         end else begin
            case (rx_mode)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = 1'($urandom_range(0, 1));
               2: begin
                  rsp_chan.ready = 1'b1;
                  if ($urandom_range(0, 15) == 0) rx_stall = $urandom_range(1, 40);
               end
               default: rsp_chan.ready = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic send_sample(logic signed [16:0] ang, logic [31:0] stamp);
      int g;
      if (burst_left <= 0) begin
         g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (g) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end else begin
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.angle_sample = ang;
      req_chan.time_stamp = stamp;
      do @(posedge clock); while (!req_chan.ready);
      burst_left--;
      cur_stamp = stamp;
   endtask

   // Hold off until every result is back and the pipe has drained.
   task automatic drain_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      burst_left = 0;
      while (sb.expected_duty_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_regs(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                            logic [31:0] kd, logic [31:0] db, logic [31:0] up,
                            logic [31:0] lo, logic [31:0] neu);
      write_csr(CSR_SETPOINT, sp);
      write_csr(CSR_GAIN_P, kp);
      write_csr(CSR_GAIN_I, ki);
      write_csr(CSR_GAIN_D, kd);
      write_csr(CSR_DEAD_BAND, db);
      write_csr(CSR_INTEG_UPPER, up);
      write_csr(CSR_INTEG_LOWER, lo);
      write_csr(CSR_DUTY_NEUTRAL, neu);
   endtask

   function automatic logic [31:0] next_stamp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return cur_stamp;
      if (r < 8) return $urandom;
      if (r < 10) return 32'hFFFF_FFFF - $urandom_range(0, 300);
      if (r < 15) return cur_stamp + $urandom_range(1, 3);
      return cur_stamp + $urandom_range(1, 3000);
   endfunction

   function automatic logic signed [16:0] next_angle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 17'($urandom);
      if (r < 20) return 17'(sb.setpoint + $signed($urandom_range(0, 600)) - 300);
      return 17'($signed($urandom_range(0, 92160)) - 46080);
   endfunction

   task automatic random_phase(int n);
      repeat (n) send_sample(next_angle(), next_stamp());
   endtask

   logic [31:0] rnd_lo, rnd_up;
   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.angle_sample = '0;
      req_chan.time_stamp = '0;
      cur_stamp = '0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, field extremes, deadband edge, stalled clock.
      send_sample(17'sd0, 32'd100);
      send_sample(17'sd65535, 32'd200);
      send_sample(-17'sd65536, 32'd300);
      send_sample(17'sd100, 32'd400);
      send_sample(-17'sd205, 32'd500);
      send_sample(-17'sd206, 32'd600);
      send_sample(-17'sd206, 32'd600);
      send_sample(17'sd5000, 32'd600);
      send_sample(-17'sd5000, 32'd600);
      send_sample(-17'sd3000, 32'hFFFF_FFF0);
      send_sample(-17'sd3000, 32'h0000_0010);
      send_sample(17'sd46080, 32'h0000_0020);
      send_sample(-17'sd46080, 32'h0000_0021);
      drain_idle();

      // Huge integral step and saturated gains, zero deadband, top neutral.
      load_regs(32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd0, 32'h0000_7FFF, 32'h0000_8000, 32'd127);
      send_sample(-17'sd65536, cur_stamp + 1);
      send_sample(-17'sd65536, cur_stamp + 32'hF000_0000);
      send_sample(17'sd65535, cur_stamp + 32'hF000_0000);
      send_sample(17'sd1, cur_stamp);
      send_sample(-17'sd1, cur_stamp + 1);
      drain_idle();

      // Crossed integral bounds, zero gains, widest deadband, zero neutral.
      load_regs(32'h0000_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF,
                32'hFFFF_FF00, 32'h0000_0100, 32'd0);
      send_sample(17'sd0, cur_stamp + 5);
      send_sample(17'sd65535, cur_stamp + 5);
      send_sample(-17'sd65536, cur_stamp + 5);
      drain_idle();

      load_regs(32'd0, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 32'(RST_DEAD_BAND),
                32'(RST_INTEG_UPPER), 32'(RST_INTEG_LOWER), 32'(RST_DUTY_NEUTRAL));
      random_phase(250);
      drain_idle();

      load_regs(32'h0000_B400, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd0, 32'h0000_7FFF, 32'h0000_8000, 32'd100);
      random_phase(150);
      drain_idle();

      load_regs(32'h0001_4C00, 32'd0, 32'd0, 32'd0, 32'd46080,
                32'd0, 32'd0, 32'd0);
      random_phase(100);
      drain_idle();

      repeat (6) begin
         rnd_up = $signed($urandom_range(0, 65535)) - 32768;
         rnd_lo = $signed($urandom_range(0, 65535)) - 32768;
         if ($urandom_range(0, 3) != 0 && $signed(rnd_lo[15:0]) > $signed(rnd_up[15:0])) begin
            rnd_up = rnd_lo ^ rnd_up;
            rnd_lo = rnd_lo ^ rnd_up;
            rnd_up = rnd_lo ^ rnd_up;
         end
         load_regs($signed($urandom_range(0, 92160)) - 46080,
                   $urandom_range(0, 32'h0010_0000),
                   $urandom_range(0, 32'h0000_4000),
                   ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000),
                   $urandom_range(0, 1200), rnd_up, rnd_lo,
                   ($urandom_range(0, 5) == 0) ? $urandom_range(101, 127) :
                                                 $urandom_range(0, 100));
         random_phase(210);
         drain_idle();
      end

      if (sb.fails == 0 && sb.expected_duty_q.size() == 0) begin
         $display("** pid_deadband_duty_controller_top: PASSED **");
      end else begin
         $display("** pid_deadband_duty_controller_top: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/pdc_pkg.sv
rtl/pdc_req_if.sv
rtl/pdc_rsp_if.sv
rtl/pdc_ctrl.sv
rtl/pdc_datapath.sv
rtl/pid_deadband_duty_controller_top.sv
rtl/pdc_checker.sv
verif/tb_pid_deadband_duty_controller_top.sv
